### hw/rtl/ksel_pkg.sv
// Shared constants, types and command/status bundles for the keyframe selector.
package ksel_pkg;

   localparam int MAX_CELLS   = 1024;
   localparam int ADDR_W      = $clog2(MAX_CELLS);
   localparam int CNT_W       = $clog2(MAX_CELLS + 1);
   localparam int POS_W       = 24;
   localparam int CELL_W      = 20;
   localparam int ENTRY_W     = 3 * CELL_W;
   localparam int DIV_STEPS   = POS_W;
   localparam int MIN_CELL    = 16;
   localparam int CSR_ADDR_W  = 4;

   // Decision codes
   localparam logic [2:0] DEC_OUTSIDE  = 3'd0;
   localparam logic [2:0] DEC_RECENT   = 3'd1;
   localparam logic [2:0] DEC_NEW_CELL = 3'd2;
   localparam logic [2:0] DEC_TAKEN    = 3'd3;
   localparam logic [2:0] DEC_FULL     = 3'd4;

   // Register indexes
   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_CELL   = 2'd1;
   localparam logic [1:0] REG_WINDOW = 2'd2;

   typedef struct packed {
      logic load;       // latch a new request
      logic clr_count;  // empty the occupied table
      logic sq_step;    // one step of the squaring sequence
      logic div_start;  // load the dividers
      logic div_step;   // one quotient bit
      logic cell_fix;   // turn quotients into floor cell coordinates
      logic rd_en;      // read table entry at search index
      logic idx_inc;    // advance search index
      logic wr_en;      // append the cell at the fill count
   } cmd_type;

   typedef struct packed {
      logic sq_last;
      logic outside;
      logic recent;
      logic div_last;
      logic at_end;
      logic full;
      logic match;
   } stat_type;

endpackage

### hw/rtl/ksel_ram.sv
// Generic single-port RAM with registered read.
module ksel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### hw/rtl/ksel_ctrl.sv
// Controller state machine sequencing one request through the datapath.
module ksel_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               first_of_query,
   input  ksel_pkg::stat_type stat,
   output ksel_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_valid,
   output logic [2:0]         rsp_decision
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_ABS, ST_SQR, ST_CMP, ST_DIV, ST_FIX, ST_SRCH, ST_CHK
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [2:0] dec_ff, dec_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      dec_in   = dec_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load      = 1'b1;
               cmd.clr_count = first_of_query;
               state_in      = ST_ABS;
            end
         end
         ST_ABS: state_in = ST_SQR;
         ST_SQR: begin
            cmd.sq_step = 1'b1;
            if (stat.sq_last) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (stat.outside) begin
               dec_in   = ksel_pkg::DEC_OUTSIDE;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (stat.recent) begin
               dec_in   = ksel_pkg::DEC_RECENT;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.cell_fix = 1'b1;
            state_in     = ST_SRCH;
         end
         ST_SRCH: begin
            if (!stat.at_end) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_CHK;
            end else if (stat.full) begin
               dec_in   = ksel_pkg::DEC_FULL;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.wr_en = 1'b1;
               dec_in    = ksel_pkg::DEC_NEW_CELL;
               valid_in  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_CHK: begin
            if (stat.match) begin
               dec_in   = ksel_pkg::DEC_TAKEN;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SRCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and the response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         dec_ff   <= ksel_pkg::DEC_OUTSIDE;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         dec_ff   <= dec_in;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = valid_ff;
   assign rsp_decision = dec_ff;
endmodule

### hw/rtl/ksel_dp.sv
// Datapath: distance, age test, cell dividers, occupied table and its search.
module ksel_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ksel_pkg::cmd_type             cmd,
   output ksel_pkg::stat_type            stat,
   input  logic [22:0]                   search_radius,
   input  logic [15:0]                   cell_size,
   input  logic [31:0]                   recent_window,
   input  logic [15:0]                   keyframe_index,
   input  logic signed [ksel_pkg::POS_W-1:0] keyframe_x,
   input  logic signed [ksel_pkg::POS_W-1:0] keyframe_y,
   input  logic signed [ksel_pkg::POS_W-1:0] keyframe_z,
   input  logic [31:0]                   keyframe_time,
   input  logic [31:0]                   newest_time,
   input  logic signed [ksel_pkg::POS_W-1:0] center_x,
   input  logic signed [ksel_pkg::POS_W-1:0] center_y,
   input  logic signed [ksel_pkg::POS_W-1:0] center_z,
   output logic [15:0]                   result_index
);
   localparam int PW = ksel_pkg::POS_W;
   localparam int CW = ksel_pkg::CELL_W;

   logic [15:0]          index_ff;
   logic signed [PW-1:0] kpos_ff [3];
   logic signed [PW-1:0] cpos_ff [3];
   logic [31:0]          ktime_ff, ntime_ff;
   logic [PW-1:0]        adiff_ff [3];
   logic                 recent_ff;
   logic [2:0]           sq_cnt_ff;
   logic [2*PW-1:0]      prod_ff;
   logic [2*PW+1:0]      d2_ff;
   logic [2*PW-1:0]      r2_ff;
   logic [15:0]          divisor_ff;
   logic [15:0]          rem_ff [3];
   logic [PW-1:0]        quo_ff [3];
   logic [4:0]           div_cnt_ff;
   logic [CW-1:0]        cell_ff [3];
   logic [ksel_pkg::CNT_W-1:0] count_ff, idx_ff;
   logic [PW-1:0]        sq_op;
   logic [33:0]          age;
   logic [ksel_pkg::ENTRY_W-1:0] rdata, wdata;
   logic [ksel_pkg::ADDR_W-1:0]  addr;

   // Pick the squaring operand for this step
   always_comb begin
      case (sq_cnt_ff)
         3'd0:    sq_op = adiff_ff[0];
         3'd1:    sq_op = adiff_ff[1];
         3'd2:    sq_op = adiff_ff[2];
         default: sq_op = {1'b0, search_radius};
      endcase
   end

   assign age = {2'b00, ntime_ff} - {2'b00, ktime_ff};

   // Request capture, distance and age
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         index_ff   <= keyframe_index;
         kpos_ff[0] <= keyframe_x;
         kpos_ff[1] <= keyframe_y;
         kpos_ff[2] <= keyframe_z;
         cpos_ff[0] <= center_x;
         cpos_ff[1] <= center_y;
         cpos_ff[2] <= center_z;
         ktime_ff   <= keyframe_time;
         ntime_ff   <= newest_time;
      end
      for (int a = 0; a < 3; a++) begin
         adiff_ff[a] <= (kpos_ff[a] >= cpos_ff[a]) ? PW'(kpos_ff[a] - cpos_ff[a])
                                                   : PW'(cpos_ff[a] - kpos_ff[a]);
      end
      recent_ff <= $signed(age) < $signed({2'b00, recent_window});
      if (cmd.sq_step) begin
         prod_ff <= sq_op * sq_op;
         if (sq_cnt_ff == 3'd1) begin
            d2_ff <= {2'b00, prod_ff};
         end else if (sq_cnt_ff == 3'd2 || sq_cnt_ff == 3'd3) begin
            d2_ff <= d2_ff + {2'b00, prod_ff};
         end else if (sq_cnt_ff == 3'd4) begin
            r2_ff <= prod_ff;
         end
      end
   end

   // Squaring step counter
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         sq_cnt_ff <= '0;
      end else if (cmd.sq_step) begin
         sq_cnt_ff <= sq_cnt_ff + 3'd1;
      end
   end

   // Three restoring dividers on coordinate magnitudes, one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         divisor_ff <= (cell_size < 16'(ksel_pkg::MIN_CELL)) ? 16'(ksel_pkg::MIN_CELL)
                                                            : cell_size;
         div_cnt_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            rem_ff[a] <= '0;
            quo_ff[a] <= kpos_ff[a][PW-1] ? PW'(-kpos_ff[a]) : PW'(kpos_ff[a]);
         end
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 5'd1;
         for (int a = 0; a < 3; a++) begin
            if ({rem_ff[a], quo_ff[a][PW-1]} >= {1'b0, divisor_ff}) begin
               rem_ff[a] <= 16'({rem_ff[a], quo_ff[a][PW-1]} - {1'b0, divisor_ff});
               quo_ff[a] <= {quo_ff[a][PW-2:0], 1'b1};
            end else begin
               rem_ff[a] <= {rem_ff[a][14:0], quo_ff[a][PW-1]};
               quo_ff[a] <= {quo_ff[a][PW-2:0], 1'b0};
            end
         end
      end
      // Round negative quotients toward minus infinity
      if (cmd.cell_fix) begin
         for (int a = 0; a < 3; a++) begin
            cell_ff[a] <= kpos_ff[a][PW-1]
               ? CW'(-(quo_ff[a] + PW'(rem_ff[a] != 16'd0)))
               : CW'(quo_ff[a]);
         end
      end
   end

   // Fill count and search index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load && cmd.clr_count) begin
         count_ff <= '0;
      end else if (cmd.wr_en) begin
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.cell_fix) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign wdata = {cell_ff[0], cell_ff[1], cell_ff[2]};
   assign addr  = cmd.wr_en ? count_ff[ksel_pkg::ADDR_W-1:0]
                            : idx_ff[ksel_pkg::ADDR_W-1:0];

   ksel_ram #(
      .WIDTH (ksel_pkg::ENTRY_W),
      .DEPTH (ksel_pkg::MAX_CELLS)
   ) u_cells (
      .clock (clock),
      .wr_en (cmd.wr_en),
      .rd_en (cmd.rd_en),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   assign stat.sq_last  = (sq_cnt_ff == 3'd4);
   assign stat.outside  = d2_ff > {2'b00, r2_ff};
   assign stat.recent   = recent_ff;
   assign stat.div_last = (div_cnt_ff == 5'(ksel_pkg::DIV_STEPS - 1));
   assign stat.at_end   = (idx_ff == count_ff);
   assign stat.full     = (count_ff == ksel_pkg::CNT_W'(ksel_pkg::MAX_CELLS));
   assign stat.match    = (rdata == wdata);
   assign result_index  = index_ff;
endmodule

### hw/rtl/keyframe_voxel_thinning_selector.sv
// Top level: register block, controller and datapath of the keyframe selector.
//
// Usage: raise start with one keyframe request on the req_ ports while busy is
// low; the request is taken at that edge. Exactly one response follows: the
// rsp_ ports carry it for one cycle, marked by rsp_valid, and the receiver has
// no way to stall it. Registers (search_radius at 0x0, cell_size at 0x4,
// recent_window at 0x8) are written and read over the APB-style port. The user
// must do so only while the block is idle; the block does not enforce it.
// The squared distance runs through one shared multiplier (five steps), the
// cell coordinates through three bit-serial dividers (24 steps), and the table
// search reads and compares one entry at a time in a single-port RAM. The next
// request can be taken in the cycle the response is shown.
// Reset returns the registers to their defaults and empties the table; table
// contents themselves are not cleared, the fill count guards them.
module keyframe_voxel_thinning_selector (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_first_of_query,
   input  logic [15:0] req_keyframe_index,
   input  logic signed [23:0] req_keyframe_x,
   input  logic signed [23:0] req_keyframe_y,
   input  logic signed [23:0] req_keyframe_z,
   input  logic [31:0] req_keyframe_time,
   input  logic [31:0] req_newest_time,
   input  logic signed [23:0] req_center_x,
   input  logic signed [23:0] req_center_y,
   input  logic signed [23:0] req_center_z,
   output logic        rsp_valid,
   output logic [15:0] rsp_result_index,
   output logic        rsp_selected,
   output logic [2:0]  rsp_decision,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [ksel_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [22:0]        radius_ff;
   logic [15:0]        cell_ff;
   logic [31:0]        window_ff;
   logic [1:0]         reg_idx;
   logic               csr_wr;
   ksel_pkg::cmd_type  cmd;
   ksel_pkg::stat_type stat;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 23'd12800;
         cell_ff   <= 16'd512;
         window_ff <= 32'd10000;
      end else if (csr_wr) begin
         case (reg_idx)
            ksel_pkg::REG_RADIUS: radius_ff <= pwdata[22:0];
            ksel_pkg::REG_CELL:   cell_ff   <= pwdata[15:0];
            ksel_pkg::REG_WINDOW: window_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (reg_idx)
         ksel_pkg::REG_RADIUS: prdata = {9'd0, radius_ff};
         ksel_pkg::REG_CELL:   prdata = {16'd0, cell_ff};
         ksel_pkg::REG_WINDOW: prdata = window_ff;
         default:              prdata = '0;
      endcase
   end

   ksel_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .first_of_query (req_first_of_query),
      .stat           (stat),
      .cmd            (cmd),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_decision   (rsp_decision)
   );

   ksel_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .search_radius  (radius_ff),
      .cell_size      (cell_ff),
      .recent_window  (window_ff),
      .keyframe_index (req_keyframe_index),
      .keyframe_x     (req_keyframe_x),
      .keyframe_y     (req_keyframe_y),
      .keyframe_z     (req_keyframe_z),
      .keyframe_time  (req_keyframe_time),
      .newest_time    (req_newest_time),
      .center_x       (req_center_x),
      .center_y       (req_center_y),
      .center_z       (req_center_z),
      .result_index   (rsp_result_index)
   );

   assign rsp_selected = (rsp_decision == ksel_pkg::DEC_RECENT) ||
                         (rsp_decision == ksel_pkg::DEC_NEW_CELL);
endmodule

### dv/testbench.sv
// Self-checking testbench for the keyframe voxel thinning selector.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_first_of_query = 1'b0;
   logic [15:0] req_keyframe_index = '0;
   logic signed [23:0] req_keyframe_x = '0, req_keyframe_y = '0, req_keyframe_z = '0;
   logic [31:0] req_keyframe_time = '0, req_newest_time = '0;
   logic signed [23:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic rsp_valid;
   logic [15:0] rsp_result_index;
   logic rsp_selected;
   logic [2:0] rsp_decision;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ksel_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   typedef struct packed {
      logic        first;
      logic [15:0] index;
      logic signed [23:0] kx, ky, kz;
      logic [31:0] ktime, ntime;
      logic signed [23:0] cx, cy, cz;
   } keyframe_type;

   typedef struct packed {
      logic [15:0] index;
      logic        selected;
      logic [2:0]  decision;
   } choice_type;

   keyframe_voxel_thinning_selector uut (.*);

   // Predictor state
   logic [22:0] radius_q = 23'd12800;
   logic [15:0] cell_q = 16'd512;
   logic [31:0] window_q = 32'd10000;
   logic signed [19:0] cells_x[ksel_pkg::MAX_CELLS], cells_y[ksel_pkg::MAX_CELLS],
                       cells_z[ksel_pkg::MAX_CELLS];
   int unsigned fill_count = 0;

   choice_type pending_choices[$];
   int unsigned mismatch_count = 0, checked_count = 0, sent_count = 0;
   int unsigned decision_seen[5] = '{default: 0};
   bit gaps_on = 1'b1;

   initial forever #5 clock = ~clock;

   initial begin
      #100ms;
      $display("Timeout waiting for responses");
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic logic signed [19:0] floor_cell(input logic signed [23:0] c,
                                                   input longint d);
      longint v;
      v = c;
      if (v >= 0) return 20'(v / d);
      return 20'(-((-v + d - 1) / d));
   endfunction

   // Decide one keyframe and update the occupied table
   function automatic choice_type select_keyframe(input keyframe_type k);
      choice_type r;
      longint dx, dy, dz, age, d;
      logic [63:0] d2, r2;
      logic signed [19:0] vx, vy, vz;
      bit hit;
      hit = 1'b0;
      if (k.first) fill_count = 0;
      dx = longint'(k.kx) - longint'(k.cx);
      dy = longint'(k.ky) - longint'(k.cy);
      dz = longint'(k.kz) - longint'(k.cz);
      d2 = dx * dx + dy * dy + dz * dz;
      r2 = {41'd0, radius_q} * {41'd0, radius_q};
      age = longint'({32'd0, k.ntime}) - longint'({32'd0, k.ktime});
      r.index = k.index;
      if (d2 > r2) r.decision = ksel_pkg::DEC_OUTSIDE;
      else if (age < longint'({32'd0, window_q})) r.decision = ksel_pkg::DEC_RECENT;
      else begin
         d = (cell_q < 16) ? 16 : cell_q;
         vx = floor_cell(k.kx, d);
         vy = floor_cell(k.ky, d);
         vz = floor_cell(k.kz, d);
         for (int i = 0; i < fill_count; i++)
            if (cells_x[i] == vx && cells_y[i] == vy && cells_z[i] == vz) hit = 1'b1;
         if (hit) r.decision = ksel_pkg::DEC_TAKEN;
         else if (fill_count >= ksel_pkg::MAX_CELLS) r.decision = ksel_pkg::DEC_FULL;
         else begin
            cells_x[fill_count] = vx;
            cells_y[fill_count] = vy;
            cells_z[fill_count] = vz;
            fill_count++;
            r.decision = ksel_pkg::DEC_NEW_CELL;
         end
      end
      r.selected = (r.decision == ksel_pkg::DEC_RECENT ||
                    r.decision == ksel_pkg::DEC_NEW_CELL);
      return r;
   endfunction

   // Check each response against the oldest prediction
   always @(posedge clock) begin
      choice_type want;
      if (!reset && rsp_valid) begin
         if (pending_choices.size() == 0) report_mismatch("unexpected response", 1, 0);
         else begin
            want = pending_choices[0];
            pending_choices.delete(0);
            checked_count++;
            if (rsp_result_index !== want.index)
               report_mismatch("result_index", rsp_result_index, want.index);
            if (rsp_selected !== want.selected)
               report_mismatch("selected", rsp_selected, want.selected);
            if (rsp_decision !== want.decision)
               report_mismatch("decision", rsp_decision, want.decision);
            else if (want.decision <= ksel_pkg::DEC_FULL) decision_seen[want.decision]++;
         end
      end
   end

   // Send one request once the block is free, with random gaps before it while gaps_on is set
   task automatic send_keyframe(input keyframe_type k);
      @(negedge clock);
      while (busy !== 1'b0 || (gaps_on && $urandom_range(99) < 20)) @(negedge clock);
      start <= 1'b1;
      {req_first_of_query, req_keyframe_index, req_keyframe_x, req_keyframe_y,
       req_keyframe_z, req_keyframe_time, req_newest_time, req_center_x,
       req_center_y, req_center_z} <= k;
      do @(posedge clock); while (busy !== 1'b0);
      pending_choices.insert(pending_choices.size(), select_keyframe(k));
      sent_count++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain_responses();
      while (pending_choices.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Write one register over APB while the block is idle
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      drain_responses();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ksel_pkg::CSR_ADDR_W'(idx) << 2; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         ksel_pkg::REG_RADIUS: radius_q = value[22:0];
         ksel_pkg::REG_CELL:   cell_q = value[15:0];
         ksel_pkg::REG_WINDOW: window_q = value;
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   function automatic logic signed [23:0] near_pos(input logic signed [23:0] c,
                                                  input int span);
      return c + 24'($signed($urandom_range(2 * span)) - span);
   endfunction

   // Random keyframe near a center, well inside most of the time
   function automatic keyframe_type random_keyframe(input bit first, input int span);
      keyframe_type k;
      k = '0;
      k.first = first;
      k.index = 16'($urandom);
      k.cx = 24'($urandom); k.cy = 24'($urandom); k.cz = 24'($urandom);
      if ($urandom_range(9) < 8) begin
         k.kx = near_pos(k.cx, span);
         k.ky = near_pos(k.cy, span);
         k.kz = near_pos(k.cz, span);
      end else begin
         k.kx = 24'($urandom); k.ky = 24'($urandom); k.kz = 24'($urandom);
      end
      k.ntime = $urandom;
      case ($urandom_range(3))
         0: k.ktime = $urandom;
         1: k.ktime = k.ntime - $urandom_range(2 * window_q[15:0]);
         default: k.ktime = k.ntime - window_q - $urandom_range(1000);
      endcase
      return k;
   endfunction

   task automatic test_field_extremes();
      keyframe_type k;
      write_reg(ksel_pkg::REG_RADIUS, 32'h7FFFFF);
      write_reg(ksel_pkg::REG_WINDOW, 32'd0);
      k = '0; k.first = 1'b1; k.index = 16'hFFFF;
      k.kx = 24'sh7FFFFF; k.ky = 24'sh800000; k.kz = 24'sh7FFFFF;
      k.cx = 24'sh800000; k.cy = 24'sh7FFFFF; k.cz = 24'sh800000;
      send_keyframe(k);
      k.first = 1'b0; k.index = 16'h0;
      k.kx = 24'sh7FFFFF; k.ky = 24'sh7FFFFF; k.kz = 24'sh7FFFFF;
      k.cx = 24'sh7FFFFF; k.cy = 24'sh7FFFFF; k.cz = 24'sh7FFFFF;
      k.ktime = 32'h0; k.ntime = 32'hFFFFFFFF;
      send_keyframe(k);
      k.kx = 24'sh800000; k.ky = 24'sh800000; k.kz = 24'sh800000;
      k.cx = 24'sh800000; k.cy = 24'sh800000; k.cz = 24'sh800000;
      send_keyframe(k);
      send_keyframe(k);
      // keyframe newer than newest counts as recent
      k.ktime = 32'hFFFFFFFF; k.ntime = 32'h0;
      send_keyframe(k);
      k.kx = -24'sd1; k.ky = -24'sd16; k.kz = 24'sd15;
      k.ktime = 32'd0; k.ntime = 32'd5;
      send_keyframe(k);
   endtask

   task automatic test_radius_boundary();
      keyframe_type k;
      write_reg(ksel_pkg::REG_RADIUS, 32'd300);
      write_reg(ksel_pkg::REG_WINDOW, 32'd1000);
      k = '0; k.first = 1'b1; k.index = 16'd7;
      k.kx = 24'sd300; k.ntime = 32'd999;
      send_keyframe(k);
      k.kx = 24'sd301; send_keyframe(k);
      k.kx = 24'sd0; k.ky = -24'sd100; k.kz = 24'sd200; k.cx = -24'sd200;
      send_keyframe(k);
      k.ky = -24'sd101; send_keyframe(k);
      k.ntime = 32'd1000; k.ky = -24'sd100; send_keyframe(k);
      send_keyframe(k);
      write_reg(ksel_pkg::REG_RADIUS, 32'd0);
      k.kx = 24'sd5; k.cx = 24'sd5; k.ky = 24'sd0; k.kz = 24'sd0; send_keyframe(k);
      k.kx = 24'sd6; send_keyframe(k);
   endtask

   task automatic test_small_cells();
      keyframe_type k;
      write_reg(ksel_pkg::REG_RADIUS, 32'h7FFFFF);
      write_reg(ksel_pkg::REG_WINDOW, 32'd0);
      write_reg(ksel_pkg::REG_CELL, 32'd0);
      k = '0; k.first = 1'b1;
      for (int i = 0; i < 4; i++) begin
         k.index = 16'(i); k.kx = 24'((i < 2) ? 15 + i : -16 - i);
         send_keyframe(k);
         k.first = 1'b0;
      end
      write_reg(ksel_pkg::REG_CELL, 32'd15);
      k.kx = 24'sd17; send_keyframe(k);
      write_reg(ksel_pkg::REG_CELL, 32'hFFFF);
      k.kx = 24'sh7FFFFF; send_keyframe(k);
   endtask

   // Fill the table to the limit, then probe full with new and old cells
   task automatic test_table_full();
      keyframe_type k;
      write_reg(ksel_pkg::REG_CELL, 32'd16);
      write_reg(ksel_pkg::REG_RADIUS, 32'h7FFFFF);
      write_reg(ksel_pkg::REG_WINDOW, 32'd0);
      k = '0; k.first = 1'b1; k.ktime = 32'd0; k.ntime = 32'hFFFF;
      for (int i = 0; i <= ksel_pkg::MAX_CELLS; i++) begin
         // run a long stretch with no random gaps
         gaps_on = (i < 300 || i > 700);
         k.index = 16'(i); k.kx = 24'(16 * i); k.ky = 24'(-16 * (i % 7));
         send_keyframe(k);
         k.first = 1'b0;
      end
      gaps_on = 1'b1;
      k.kx = 24'sd0; k.ky = 24'sd0; send_keyframe(k);
      k.kz = 24'sd160; send_keyframe(k);
   endtask

   task automatic test_random_queries();
      keyframe_type k;
      for (int q = 0; q < 5; q++) begin
         if (q == 1) gaps_on = 1'b0;
         if (q == 4) gaps_on = 1'b1;
         if (q % 2 == 0) begin
            write_reg(ksel_pkg::REG_RADIUS,
                      $urandom_range(3) == 0 ? $urandom : $urandom_range(20000));
            write_reg(ksel_pkg::REG_CELL,
                      $urandom_range(3) == 0 ? $urandom : $urandom_range(2000));
            write_reg(ksel_pkg::REG_WINDOW,
                      $urandom_range(3) == 0 ? $urandom : $urandom_range(20000));
         end
         for (int i = 0; i < 12; i++) begin
            k = random_keyframe(i == 0 ? 1'b1 : ($urandom_range(40) == 0), 3000);
            if (i > 0 && $urandom_range(3) == 0) begin
               k.cx = req_center_x; k.cy = req_center_y; k.cz = req_center_z;
               k.kx = near_pos(k.cx, 2000); k.ky = near_pos(k.cy, 2000);
               k.kz = near_pos(k.cz, 2000);
            end
            send_keyframe(k);
         end
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_field_extremes();
      test_radius_boundary();
      test_small_cells();
      test_random_queries();
      test_table_full();
      drain_responses();
      $display("Sent %0d keyframes, checked %0d responses", sent_count, checked_count);
      $display("Decisions outside/recent/new/taken/full: %0d/%0d/%0d/%0d/%0d",
               decision_seen[0], decision_seen[1], decision_seen[2],
               decision_seen[3], decision_seen[4]);
      if (mismatch_count == 0 && pending_choices.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
